// ----- hw/rtl/srng_pkg.sv -----
// ----------------------------------------------------------------------------
// srng_pkg: shared constants and types for the shuffled minimal standard RNG
// Generator constants, shuffle table geometry and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package srng_pkg;

   // Generator word: values live in 1 .. 2^31-2
   localparam int VALUE_W      = 31;
   localparam int MULT_W       = 15;
   localparam int PROD_W       = VALUE_W + MULT_W;

   localparam logic [VALUE_W-1:0] MODULUS    = 31'h7FFF_FFFF;
   localparam logic [MULT_W-1:0]  MULTIPLIER = 15'd16807;

   // Shuffle table; depth is a power of two in 8 .. 64
   localparam int TABLE_DEPTH  = 32;
   localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

   // Slot selection divides the previous word by this constant. For a
   // power-of-two depth the divisor is a power of two, so it is a shift.
   localparam longint SLOT_DIVISOR = 1 + (2147483647 - 1) / TABLE_DEPTH;
   localparam int     SLOT_SHIFT   = $clog2(SLOT_DIVISOR);

   // Initialisation: warm-up steps followed by one step per table entry
   localparam int WARMUP_STEPS = 8;
   localparam int INIT_STEPS   = WARMUP_STEPS + TABLE_DEPTH;
   localparam int STEP_W       = $clog2(INIT_STEPS);

   localparam logic [VALUE_W-1:0] SEED_FALLBACK = 31'd1;
   localparam logic [VALUE_W-1:0] SEED_RESET    = 31'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT_SEED,
      ST_INIT_MUL,
      ST_INIT_FOLD,
      ST_DRAW_MUL,
      ST_DRAW_FOLD
   } state_type;

   // Control from the state decoder to the datapath
   typedef struct packed {
      logic req_ready;
      logic ld_seed;
      logic ld_gen;
      logic step_clr;
      logic step_inc;
      logic fill_wr;
      logic draw_wr;
      logic ld_rsp;
   } ctrl_type;

endpackage : srng_pkg

`default_nettype wire

// ----- hw/rtl/shuffled_minimal_standard_rng.sv -----
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng: Park-Miller generator with Bays-Durham shuffle
// Each request word returns one 31-bit value in 1 .. 2^31-2; divide it by
// 2^31-1 in software for a uniform deviate. A normal draw forms the product
// and reads the table slot in the accept cycle; the fold state then folds the
// product, writes the slot and loads the response word once the output
// register is free. The first request after reset, a request with req_reseed
// set, and any request while the previous output is zero first reinitialise:
// load csr_seed (0 or 2^31-1 become 1), 8 warm-up steps, then one step per
// table entry filling from the top slot down. Each step uses the single
// multiply-modulo unit in a multiply state and then a fold state. The
// response sits in an output register, so a new request may be accepted
// while it waits. Write csr_seed only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_minimal_standard_rng
   import srng_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [VALUE_W-1:0] csr_seed,

   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_reseed,

   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [VALUE_W-1:0] rsp_random_value
);

   state_type           state_ff, state_in;
   ctrl_type            ctrl;

   logic [VALUE_W-1:0]  seed_ff;
   logic [VALUE_W-1:0]  gen_ff;
   logic [VALUE_W-1:0]  last_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;

   logic [VALUE_W-1:0]  shuffle_mem [TABLE_DEPTH];
   logic [VALUE_W-1:0]  rd_data_ff;

   logic [VALUE_W-1:0]  next_gen;
   logic [VALUE_W-1:0]  seed_fixed;
   logic [TABLE_AW-1:0] slot;
   logic [TABLE_AW-1:0] fill_addr;
   logic                req_fire;
   logic                need_init;
   logic                step_last;
   logic                step_warm;
   logic                out_free;

   // Shared arithmetic: always works on the current generator word
   srng_mulmod u_mulmod (
      .clock   (clock),
      .operand (gen_ff),
      .result  (next_gen)
   );

   assign csr_ready = 1'b1;
   assign req_ready = ctrl.req_ready;
   assign req_fire  = req_valid && ctrl.req_ready;
   assign need_init = req_reseed || (last_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Seed of zero or of the modulus would lock the generator: use one
   assign seed_fixed = ((seed_ff == '0) || (seed_ff == MODULUS)) ? SEED_FALLBACK : seed_ff;

   // Previous output picks the slot; top bits for a power-of-two depth
   assign slot = TABLE_AW'(last_ff >> SLOT_SHIFT);

   // Fill runs from the top entry down, entry 0 last
   assign step_last = (step_ff == STEP_W'(INIT_STEPS - 1));
   assign step_warm = (step_ff < STEP_W'(WARMUP_STEPS));
   assign fill_addr = TABLE_AW'(STEP_W'(INIT_STEPS - 1) - step_ff);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = need_init ? ST_INIT_SEED : ST_DRAW_FOLD;
            end
         end
         ST_INIT_SEED: state_in = ST_INIT_MUL;
         ST_INIT_MUL:  state_in = ST_INIT_FOLD;
         ST_INIT_FOLD: state_in = step_last ? ST_DRAW_MUL : ST_INIT_MUL;
         ST_DRAW_MUL:  state_in = ST_DRAW_FOLD;
         ST_DRAW_FOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------ decode
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: ctrl.req_ready = 1'b1;
         ST_INIT_SEED: begin
            ctrl.ld_seed  = 1'b1;
            ctrl.step_clr = 1'b1;
         end
         ST_INIT_MUL: ;
         ST_INIT_FOLD: begin
            ctrl.ld_gen   = 1'b1;
            ctrl.step_inc = 1'b1;
            ctrl.fill_wr  = !step_warm;
         end
         ST_DRAW_MUL: ;
         ST_DRAW_FOLD: begin
            ctrl.ld_gen  = out_free;
            ctrl.draw_wr = out_free;
            ctrl.ld_rsp  = out_free;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         gen_ff       <= '0;
         last_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            seed_ff <= csr_seed;
         end

         // Generator word: load the seed, or advance through the unit
         if (ctrl.ld_seed) begin
            gen_ff <= seed_fixed;
         end else if (ctrl.ld_gen) begin
            gen_ff <= next_gen;
         end

         // Previous output: entry 0 at the end of the fill, else the slot read
         if (ctrl.fill_wr && step_last) begin
            last_ff <= next_gen;
         end else if (ctrl.draw_wr) begin
            last_ff <= rd_data_ff;
         end

         if (ctrl.step_clr) begin
            step_ff <= '0;
         end else if (ctrl.step_inc && !step_last) begin
            step_ff <= step_ff + STEP_W'(1);
         end

         if (ctrl.ld_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------ payload regs
   always_ff @(posedge clock) begin
      if (ctrl.ld_rsp) begin
         rsp_value_ff <= rd_data_ff;
      end
   end

   // Shuffle table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.fill_wr) begin
         shuffle_mem[fill_addr] <= next_gen;
      end else if (ctrl.draw_wr) begin
         shuffle_mem[slot] <= next_gen;
      end
      rd_data_ff <= shuffle_mem[slot];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   // -------------------------------------------------------------- assertions
   // A draw that skips initialisation goes straight to the fold cycle
   a_fast_draw: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !need_init) |=> (state_ff == ST_DRAW_FOLD))
      else $error("draw without init did not reach fold");

   // A draw never runs on an unfilled table
   a_draw_filled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW_FOLD) |-> (last_ff != '0))
      else $error("draw with zero previous output");

   // Every response word is a nonzero generator value
   a_rsp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff != '0) && (rsp_value_ff != MODULUS))
      else $error("response outside generator range");

   // Fill stops at the final step and leads into a draw
   a_init_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT_FOLD && step_last) |=> (state_ff == ST_DRAW_MUL))
      else $error("initialisation did not hand over to draw");

endmodule : shuffled_minimal_standard_rng

`default_nettype wire

// ----- hw/rtl/srng_mulmod.sv -----
// ----------------------------------------------------------------------------
// srng_mulmod: shared multiply-by-16807 modulo 2^31-1 unit
// Registers the product, then folds it against the Mersenne modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module srng_mulmod
   import srng_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [VALUE_W-1:0] operand,
   output logic      [VALUE_W-1:0] result
);

   logic [PROD_W-1:0]  product_ff;
   logic [PROD_W-1:0]  product_in;
   logic [VALUE_W:0]   fold_sum;

   assign product_in = PROD_W'(operand) * PROD_W'(MULTIPLIER);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // 2^31 == 1 mod M: add the high part to the low part, subtract M once
   always_comb begin
      fold_sum = {1'b0, product_ff[VALUE_W-1:0]}
               + (VALUE_W+1)'(product_ff[PROD_W-1:VALUE_W]);
      if (fold_sum >= {1'b0, MODULUS}) begin
         result = VALUE_W'(fold_sum - {1'b0, MODULUS});
      end else begin
         result = fold_sum[VALUE_W-1:0];
      end
   end

endmodule : srng_mulmod

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for shuffled_minimal_standard_rng
// Drives draw requests and seed writes with random gaps and stalls, predicts
// every returned word with an independent Park-Miller / Bays-Durham model and
// compares each response against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------

module tb;
   import srng_pkg::*;

   // Random phases, each opened with a seed write while the block is idle
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 250;
   localparam int SCRIPT_ROWS = 20;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [VALUE_W-1:0] csr_seed   = '0;
   logic               req_valid  = 1'b0;
   logic               req_ready;
   logic               req_reseed = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready  = 1'b0;
   logic [VALUE_W-1:0] rsp_random_value;

   shuffled_minimal_standard_rng u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed         (csr_seed),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_reseed       (req_reseed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value)
   );

   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Generator model: seed register, core generator, shuffle table and the
   // previous output word, all as the block holds them after reset.
   // -------------------------------------------------------------------------
   logic [VALUE_W-1:0] seed_reg  = 31'd1;
   logic [VALUE_W-1:0] gen_word  = '0;
   logic [VALUE_W-1:0] prev_word = '0;
   logic [VALUE_W-1:0] shuffle_slots [TABLE_DEPTH];

   logic [VALUE_W-1:0] pending_values [$];   // predicted words, oldest first
   logic [VALUE_W-1:0] wanted_value;
   int                 mismatch_count = 0;
   bit                 quiet = 1'b0;         // suppress gaps and stalls

   // One step of g <- 16807 * g mod (2^31 - 1), product at full width
   function automatic logic [VALUE_W-1:0] park_miller_step(input logic [VALUE_W-1:0] g);
      logic [63:0] product;
      product = 64'(g) * 64'(MULTIPLIER);
      product = product % 64'(MODULUS);
      return product[VALUE_W-1:0];
   endfunction

   // Advance the model by one request and return the word it should produce
   function automatic logic [VALUE_W-1:0] predict_draw(input logic reseed);
      logic [VALUE_W-1:0] g;
      longint unsigned    slot;
      int                 n;
      // A reseed request, or a zero previous word (after reset), reinitialises
      if (reseed || prev_word == '0) begin
         g = seed_reg;
         // Zero would stick at zero and 2^31-1 folds to zero: both become one
         if (g == '0 || g == MODULUS) begin
            g = 31'd1;
         end
         for (n = 0; n < WARMUP_STEPS; n++) begin
            g = park_miller_step(g);
         end
         // Fill from the top slot down, so slot 0 holds the last value
         for (n = TABLE_DEPTH - 1; n >= 0; n--) begin
            g = park_miller_step(g);
            shuffle_slots[n] = g;
         end
         gen_word  = g;
         prev_word = shuffle_slots[0];
      end
      gen_word = park_miller_step(gen_word);
      // Top bits of the previous word pick the slot; saturate for safety
      slot = prev_word / SLOT_DIVISOR;
      if (slot >= TABLE_DEPTH) begin
         slot = TABLE_DEPTH - 1;
      end
      prev_word = shuffle_slots[slot];
      shuffle_slots[slot] = gen_word;
      return prev_word;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] wanted,
                                  input logic [VALUE_W-1:0] seen);
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, wanted, seen);
      mismatch_count++;
   endtask

   // -------------------------------------------------------------------------
   // Request side. Every task is entered and left on a rising edge.
   // -------------------------------------------------------------------------

   // Present one request word after a random gap and hold it until accepted
   task automatic send_request(input logic reseed);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_reseed <= reseed;
      do @(posedge clock); while (!req_ready);
      pending_values.push_back(predict_draw(reseed));
   endtask

   // Drop valid and hold off until every predicted word has come back;
   // right after an accept the queue is never empty, so valid always drops
   task automatic drain_requests();
      while (pending_values.size() != 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Write the seed register; only ever called with the block idle
   task automatic write_seed(input logic [VALUE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      seed_reg = value;
   endtask

   // -------------------------------------------------------------------------
   // Directed script: reset seed, seed extremes, seed fallbacks, a seed write
   // without reseed, and back-to-back reseeds. No output word can be read off
   // by eye, so every row is checked against the model.
   // -------------------------------------------------------------------------
   typedef struct packed {
      logic               load_seed;
      logic [VALUE_W-1:0] seed;
      logic               reseed;
   } script_row_type;

   script_row_type script [SCRIPT_ROWS] = '{
      '{1'b0, 31'h0000_0000, 1'b0},   // first draw after reset: init from seed 1
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b0, 31'h0000_0000, 1'b1},   // reseed with the reset seed
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b1, 31'h0000_0000, 1'b1},   // zero seed falls back to one
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b1, 31'h7FFF_FFFF, 1'b1},   // seed equal to the modulus falls back too
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b1, 31'h7FFF_FFFE, 1'b1},   // largest legal seed
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b1, 31'h2AAA_AAAA, 1'b1},
      '{1'b1, 31'h5555_5555, 1'b0},   // new seed, old sequence carries on
      '{1'b0, 31'h0000_0000, 1'b1},   // now the new seed takes effect
      '{1'b0, 31'h0000_0000, 1'b1},   // back-to-back reinitialisation
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b0, 31'h0000_0000, 1'b0},
      '{1'b1, 31'h0000_0001, 1'b0},
      '{1'b0, 31'h0000_0000, 1'b0}
   };

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      int                 phase;
      int                 item;
      logic               reseed;
      logic [VALUE_W-1:0] next_seed;

      for (int n = 0; n < TABLE_DEPTH; n++) begin
         shuffle_slots[n] = '0;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: seed writes always wait for the block to go idle
      for (item = 0; item < SCRIPT_ROWS; item++) begin
         if (script[item].load_seed) begin
            drain_requests();
            write_seed(script[item].seed);
         end
         send_request(script[item].reseed);
      end

      // Random part: every third phase runs flat out on both sides
      for (phase = 0; phase < PHASES; phase++) begin
         drain_requests();
         quiet = (phase % 3 == 2);
         case (phase)
            0:       next_seed = MODULUS;
            1:       next_seed = 31'h7FFF_FFFE;
            2:       next_seed = '0;
            default: next_seed = VALUE_W'($urandom_range(0, 32'h7FFF_FFFF));
         endcase
         write_seed(next_seed);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            // Reseed on the opening word of even phases, then now and again
            reseed = (item == 0 && phase % 2 == 0) || ($urandom_range(0, 24) == 0);
            // Occasionally hold off until the pipe has emptied
            if ($urandom_range(0, 149) == 0) begin
               drain_requests();
            end
            send_request(reseed);
         end
      end

      drain_requests();
      // Allow a stray response to show up before closing
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: draw a stall per word, then hold ready until accepted
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare every accepted response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_random_value);
         end else begin
            wanted_value = pending_values.pop_front();
            if (rsp_random_value !== wanted_value) begin
               report_mismatch("random_value", wanted_value, rsp_random_value);
            end
         end
      end
   end

   // Watchdog: well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- shuffled_minimal_standard_rng.f -----
hw/rtl/srng_pkg.sv
hw/rtl/srng_mulmod.sv
hw/rtl/shuffled_minimal_standard_rng.sv
dv/tb.sv
